/* rtl/core/cpfq_pkg.sv */
// Shared types and constants for the credit-paced frame queue.
// No dependencies; every other file of the block except cpfq_ram refers to this package.
`default_nettype none

package cpfq_pkg;

  // Fixed field widths of the event and result words.
  localparam int HANDLE_WIDTH    = 16;
  localparam int FUNC_WIDTH      = 3;
  localparam int CREDIT_WIDTH    = 4;
  localparam int INTERVAL_WIDTH  = 16;

  // Default store depth handed to the top level.
  localparam int QUEUE_DEPTH_DEF = 8;

  // Command queue between front and back.
  localparam int CMD_DEPTH       = 2;
  localparam int CMD_PTR_W       = 1;
  localparam int CMD_CNT_W       = 2;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CREDITS     = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REDRAW_INTERVAL = 1'd1;
  localparam logic [CREDIT_WIDTH-1:0]    MAX_CREDITS_RST     = 4'd5;

  // Event codes as they arrive on the port.
  localparam logic [FUNC_WIDTH-1:0] FUNC_RESTART = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_FRAME   = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_RUN     = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_PAUSE   = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] FUNC_STEP    = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] FUNC_TICK    = 3'd5;

  // Classified commands handed from front to back.
  localparam int OP_WIDTH = 3;
  localparam logic [OP_WIDTH-1:0] OP_NOP     = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_RESTART = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_FRAME   = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_RUN     = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_PAUSE   = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_STEP    = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_TICK    = 3'd6;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0]   func;
    logic [HANDLE_WIDTH-1:0] frame_in;
  } evt_t;

  typedef struct packed {
    logic                    show_valid;
    logic [HANDLE_WIDTH-1:0] frame_out;
    logic [CREDIT_WIDTH-1:0] credits_granted;
    logic                    rejected;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]     op;
    logic [HANDLE_WIDTH-1:0] frame;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/cpfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/cpfq_front.sv */
// Front of the frame queue: accept events, classify them into commands
// and hold them in a short command queue. Depends on cpfq_pkg.
`default_nettype none

module cpfq_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           evt_valid,
  output logic                evt_ready,
  input  wire cpfq_pkg::evt_t evt,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output cpfq_pkg::cmd_t      cmd
);

  cpfq_pkg::cmd_t                   slot [cpfq_pkg::CMD_DEPTH];
  logic [cpfq_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [cpfq_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [cpfq_pkg::CMD_CNT_W-1:0]   count;
  cpfq_pkg::cmd_t                   decoded;
  logic                             push;
  logic                             pop;

  // Classify: unused codes become a null command.
  always_comb begin
    decoded.frame = evt.frame_in;
    case (evt.func)
      cpfq_pkg::FUNC_RESTART: decoded.op = cpfq_pkg::OP_RESTART;
      cpfq_pkg::FUNC_FRAME:   decoded.op = cpfq_pkg::OP_FRAME;
      cpfq_pkg::FUNC_RUN:     decoded.op = cpfq_pkg::OP_RUN;
      cpfq_pkg::FUNC_PAUSE:   decoded.op = cpfq_pkg::OP_PAUSE;
      cpfq_pkg::FUNC_STEP:    decoded.op = cpfq_pkg::OP_STEP;
      cpfq_pkg::FUNC_TICK:    decoded.op = cpfq_pkg::OP_TICK;
      default:                decoded.op = cpfq_pkg::OP_NOP;
    endcase
  end

  assign evt_ready = (count != cpfq_pkg::CMD_CNT_W'(cpfq_pkg::CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slot[rd_ptr];
  assign push      = evt_valid && evt_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cpfq_back.sv */
// Back of the frame queue: execute commands against the frame store,
// credit limit and pacer, and hold results in an output register.
// Depends on cpfq_pkg and cpfq_ram.
`default_nettype none

module cpfq_back #(
  parameter int QUEUE_DEPTH = cpfq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cmd_valid,
  output logic                                       cmd_ready,
  input  wire cpfq_pkg::cmd_t                        cmd,
  input  wire logic [cpfq_pkg::CREDIT_WIDTH-1:0]     max_credits,
  input  wire logic [cpfq_pkg::INTERVAL_WIDTH-1:0]   redraw_interval,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output cpfq_pkg::res_t                             res
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((AW > FW) ? AW : FW) + 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                                  state, state_next;
  logic [AW-1:0]                         head_ptr, head_ptr_next;
  logic [FW-1:0]                         fill_count, fill_count_next;
  logic                                  paused, paused_next;
  logic                                  pacer_running, pacer_running_next;
  logic [cpfq_pkg::INTERVAL_WIDTH-1:0]   tick_count, tick_count_next;
  logic                                  stale;
  logic                                  res_load;
  cpfq_pkg::res_t                        res_next;

  logic                                  out_free;
  logic                                  full_speed;
  logic [cpfq_pkg::CREDIT_WIDTH-1:0]     limit;
  logic [AW-1:0]                         head_inc;
  logic [SW-1:0]                         tail_sum;
  logic [AW-1:0]                         tail_ptr;
  logic [cpfq_pkg::INTERVAL_WIDTH-1:0]   tick_inc;
  logic                                  we;
  logic [cpfq_pkg::HANDLE_WIDTH-1:0]     rd_data;
  logic                                  pop;

  cpfq_ram #(
    .WIDTH (cpfq_pkg::HANDLE_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail_ptr),
    .wdata (cmd.frame),
    .raddr (head_ptr_next),
    .rdata (rd_data)
  );

  assign out_free   = !res_valid || res_ready;
  assign full_speed = (redraw_interval == '0);
  assign limit      = (int'(max_credits) < QUEUE_DEPTH) ? max_credits
                                                         : cpfq_pkg::CREDIT_WIDTH'(QUEUE_DEPTH);
  assign head_inc   = (head_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_sum   = SW'(head_ptr) + SW'(fill_count);
  assign tail_ptr   = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);
  assign tick_inc   = tick_count + 1'b1;
  // Hold commands while the registered read still shows a just-overwritten entry.
  assign cmd_ready  = (state == ST_IDLE) && out_free && !stale;
  assign pop        = cmd_valid && cmd_ready;

  always_comb begin
    state_next         = state;
    head_ptr_next      = head_ptr;
    fill_count_next    = fill_count;
    paused_next        = paused;
    pacer_running_next = pacer_running;
    tick_count_next    = tick_count;
    we                 = 1'b0;
    res_load           = 1'b0;
    res_next           = '0;
    res_next.last      = 1'b1;

    case (state)
      ST_IDLE: begin
        if (pop) begin
          res_load = 1'b1;
          case (cmd.op)
            cpfq_pkg::OP_RESTART: begin
              head_ptr_next            = '0;
              fill_count_next          = '0;
              paused_next              = 1'b1;
              pacer_running_next       = 1'b0;
              tick_count_next          = '0;
              res_next.credits_granted = limit;
            end
            cpfq_pkg::OP_FRAME: begin
              if (int'(fill_count) >= int'(limit)) begin
                res_next.rejected = 1'b1;
              end else begin
                we = 1'b1;
                if (!paused && (full_speed || fill_count == '0)) begin
                  // Show the head; an empty queue bypasses the store.
                  res_next.show_valid      = 1'b1;
                  res_next.frame_out       = (fill_count == '0) ? cmd.frame : rd_data;
                  res_next.credits_granted = cpfq_pkg::CREDIT_WIDTH'(1);
                  head_ptr_next            = head_inc;
                  if (!full_speed) begin
                    pacer_running_next = 1'b1;
                    tick_count_next    = '0;
                  end
                end else begin
                  fill_count_next = fill_count + 1'b1;
                end
              end
            end
            cpfq_pkg::OP_RUN: begin
              paused_next = 1'b0;
              if (full_speed) begin
                if (fill_count != '0) begin
                  res_next.show_valid      = 1'b1;
                  res_next.frame_out       = rd_data;
                  res_next.credits_granted = cpfq_pkg::CREDIT_WIDTH'(1);
                  res_next.last            = (fill_count == FW'(1));
                  head_ptr_next            = head_inc;
                  fill_count_next          = fill_count - 1'b1;
                  if (fill_count != FW'(1)) begin
                    state_next = ST_FLUSH;
                  end
                end
              end else begin
                pacer_running_next = 1'b1;
                tick_count_next    = '0;
              end
            end
            cpfq_pkg::OP_PAUSE: begin
              paused_next = 1'b1;
              if (!full_speed) begin
                pacer_running_next = 1'b0;
              end
            end
            cpfq_pkg::OP_STEP: begin
              if (paused && fill_count != '0) begin
                res_next.show_valid      = 1'b1;
                res_next.frame_out       = rd_data;
                res_next.credits_granted = cpfq_pkg::CREDIT_WIDTH'(1);
                head_ptr_next            = head_inc;
                fill_count_next          = fill_count - 1'b1;
              end
            end
            cpfq_pkg::OP_TICK: begin
              if (!full_speed && pacer_running) begin
                if (tick_inc >= redraw_interval) begin
                  tick_count_next = '0;
                  if (fill_count != '0) begin
                    res_next.show_valid      = 1'b1;
                    res_next.frame_out       = rd_data;
                    res_next.credits_granted = cpfq_pkg::CREDIT_WIDTH'(1);
                    head_ptr_next            = head_inc;
                    fill_count_next          = fill_count - 1'b1;
                  end else begin
                    pacer_running_next = 1'b0;
                  end
                end else begin
                  tick_count_next = tick_inc;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          res_load                 = 1'b1;
          res_next.show_valid      = 1'b1;
          res_next.frame_out       = rd_data;
          res_next.credits_granted = cpfq_pkg::CREDIT_WIDTH'(1);
          res_next.last            = (fill_count == FW'(1));
          head_ptr_next            = head_inc;
          fill_count_next          = fill_count - 1'b1;
          if (fill_count == FW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_ptr      <= '0;
      fill_count    <= '0;
      paused        <= 1'b1;
      pacer_running <= 1'b0;
      tick_count    <= '0;
      stale         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      head_ptr      <= head_ptr_next;
      fill_count    <= fill_count_next;
      paused        <= paused_next;
      pacer_running <= pacer_running_next;
      tick_count    <= tick_count_next;
      stale         <= we && (tail_ptr == head_ptr_next);
      res_valid     <= res_load || (res_valid && !res_ready);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/credit_paced_frame_queue.sv */
// Credit-paced frame queue, top level: configuration registers, front and back.
// Depends on cpfq_pkg, cpfq_front, cpfq_back (which holds cpfq_ram).
//
// A queue of frame handles between a sender and a display. Events arrive on
// the evt channel (restart, frame, run, pause, step, tick) and each event
// yields one or more result words on the res channel; the final word of an
// event carries last. A restart empties the queue, pauses, stops the pacer and
// grants min(max_credits, QUEUE_DEPTH) credits; a frame is rejected while the
// queue holds that many handles; every shown frame returns one credit. With
// redraw_interval 0 the block runs at full speed (frames pass straight through
// while running, run flushes the queue); otherwise one frame is released each
// redraw_interval ticks while the pacer runs. Timing: the front accepts an
// event per cycle while its command queue has room; the back takes one command
// per cycle while idle with the output free, and a full-speed flush emits one
// frame per cycle while the output is free. A command after a frame written
// where the next head reads (into an empty queue that keeps it, or behind one
// queued handle shown at full speed) waits while the registered store read is
// stale. Results pass through a one-word output register; the front keeps
// taking events while a result waits, until its two command entries are full.
// Write configuration only while the block is idle.
`default_nettype none

module credit_paced_frame_queue #(
  parameter int QUEUE_DEPTH = cpfq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   evt_valid,
  output logic                                        evt_ready,
  input  wire cpfq_pkg::evt_t                         evt,
  output logic                                        res_valid,
  input  wire logic                                   res_ready,
  output cpfq_pkg::res_t                              res,
  input  wire logic                                   cfg_we,
  input  wire logic [cpfq_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [cpfq_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  logic [cpfq_pkg::CREDIT_WIDTH-1:0]   max_credits;
  logic [cpfq_pkg::INTERVAL_WIDTH-1:0] redraw_interval;
  logic                                cmd_valid;
  logic                                cmd_ready;
  cpfq_pkg::cmd_t                      cmd;

  // Configuration registers: take writes immediately, keep the low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_credits     <= cpfq_pkg::MAX_CREDITS_RST;
      redraw_interval <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpfq_pkg::CFG_MAX_CREDITS: begin
          max_credits <= cfg_data[cpfq_pkg::CREDIT_WIDTH-1:0];
        end
        cpfq_pkg::CFG_REDRAW_INTERVAL: begin
          redraw_interval <= cfg_data[cpfq_pkg::INTERVAL_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: classify events and buffer them as commands.
  cpfq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: run the store, credit check and pacer; drive the result register.
  cpfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .max_credits     (max_credits),
    .redraw_interval (redraw_interval),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // A shown frame returns exactly one credit and is never a rejection.
  a_show_credit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.show_valid |-> res.credits_granted == 4'd1 && !res.rejected)
    else $error("shown frame with wrong credit or reject flag");

  // Only a full-speed flush yields more than one word per event.
  a_multi_is_show: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> res.show_valid)
    else $error("non-final result word that shows no frame");

  // A word that shows nothing carries a zero handle.
  a_no_show_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.show_valid |-> res.frame_out == '0)
    else $error("nonzero handle on a word that shows nothing");

  // A rejection grants no credit.
  a_reject_no_credit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> res.credits_granted == '0 && res.last)
    else $error("rejection carries credits or is not final");

endmodule

`default_nettype wire
